@@ sv/rfr_pkg.sv @@
// ----------------------------------------------------------------------------
// rfr_pkg
// Shared types and constants of the reply frame receiver.
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int DEF_MAX_PAYLOAD = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  HEADER_BYTE = 8'hFB;
  localparam logic [15:0] WAIT_MAX    = 16'hFFFF;

  localparam logic [7:0]  RST_STATION = 8'd1;
  localparam logic [7:0]  RST_CMD_A   = 8'd48;
  localparam logic [7:0]  RST_CMD_B   = 8'd48;
  localparam logic [4:0]  RST_LENGTH  = 5'd1;
  localparam logic [15:0] RST_TIMEOUT = 16'd3000;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_ADDR = 3'd1,
    ST_BAD_CMD  = 3'd2,
    ST_BAD_CSUM = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STATION = 3'd0,
    REG_CMD_A   = 3'd1,
    REG_CMD_B   = 3'd2,
    REG_LENGTH  = 3'd3,
    REG_TIMEOUT = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SEEK,
    PH_ADDR,
    PH_CMD,
    PH_CMD_BADADDR,
    PH_DATA,
    PH_CSUM,
    PH_EMIT_RD,
    PH_EMIT_WR
  } phase_t;

endpackage

@@ sv/rfr_ram.sv @@
// ----------------------------------------------------------------------------
// rfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/reply_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// reply_frame_receiver_core
// Armed reply frame receiver: header seek, address and command check,
// payload capture into RAM, sum-8 checksum, then payload burst or status.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      slave      in_tvalid/in_tready   tuser: operation, tdata: rx_byte
//  out_     master     out_tvalid/out_tready tdata: status, data_byte;
//                                            tuser: has_data; tlast: last
//  cfg_     write      cfg_we                cfg_addr, cfg_wdata
//
//  An input transfer is processed combinationally; a failure or empty-payload
//  result lands in the output register at the same edge that takes it.
//  A good frame replays N stored bytes, each as a RAM read, then an output
//  load that waits for out_free; input is held off during the replay.
//  Reset is synchronous and clears phase, counters and the output valid.
//  Outside the replay, input stalls only while the output register holds
//  an untaken result.
// ----------------------------------------------------------------------------
module reply_frame_receiver_core #(
  parameter int MAX_PAYLOAD = rfr_pkg::DEF_MAX_PAYLOAD
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic [1:0]                      in_tuser,   // [1:0] operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [2:0] status, [10:3] data_byte
  output logic [0:0]                      out_tuser,  // [0] has_data
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [rfr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import rfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

  // configuration
  logic [7:0]  station_r;
  logic [7:0]  cmd_a_r;
  logic [7:0]  cmd_b_r;
  logic [4:0]  length_r;
  logic [15:0] timeout_r;

  // frame state
  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [15:0]      wait_r, wait_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;

  // output register
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [7:0]       out_data_r;
  logic             out_has_r;
  logic             out_last_r;

  logic             ld_out;
  status_t          ld_status;
  logic [7:0]       ld_data;
  logic             ld_has;
  logic             ld_last;

  logic             ram_we;
  logic [7:0]       ram_rdata;

  logic             emitting;
  logic             out_free;
  logic             in_fire;
  logic [CNT_W-1:0] eff_len;
  logic [15:0]      wait_inc;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W:0]   rd_next_cnt;
  logic             emit_last;
  logic             store_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= RST_STATION;
      cmd_a_r   <= RST_CMD_A;
      cmd_b_r   <= RST_CMD_B;
      length_r  <= RST_LENGTH;
      timeout_r <= RST_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_STATION: station_r <= cfg_wdata[7:0];
        REG_CMD_A:   cmd_a_r   <= cfg_wdata[7:0];
        REG_CMD_B:   cmd_b_r   <= cfg_wdata[7:0];
        REG_LENGTH:  length_r  <= cfg_wdata[4:0];
        REG_TIMEOUT: timeout_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign emitting  = (phase_r == PH_EMIT_RD) || (phase_r == PH_EMIT_WR);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !emitting && out_free;
  assign in_fire   = in_tvalid && in_tready;

  assign eff_len   = (32'(length_r) > 32'(MAX_PAYLOAD)) ? MAX_CNT : CNT_W'(length_r);
  assign wait_inc  = (wait_r == WAIT_MAX) ? wait_r : wait_r + 16'd1;
  assign store_ok  = byte_count_r < MAX_CNT;
  assign count_inc = store_ok ? byte_count_r + CNT_W'(1) : byte_count_r;

  assign rd_next_cnt = (CNT_W+1)'(rd_idx_r) + (CNT_W+1)'(1);
  assign emit_last   = rd_next_cnt == {1'b0, byte_count_r};

  // payload store; writes happen only while collecting and read data is used
  // only while replaying, so a write never meets a used read of the same entry
  rfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .AW    (IDX_W)
  ) u_payload (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_count_r[IDX_W-1:0]),
    .wdata (in_tdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      byte_count_r <= '0;
      sum_r        <= '0;
      wait_r       <= '0;
      rd_idx_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      sum_r        <= sum_nxt;
      wait_r       <= wait_nxt;
      rd_idx_r     <= rd_idx_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    sum_nxt        = sum_r;
    wait_nxt       = wait_r;
    rd_idx_nxt     = rd_idx_r;
    ld_out         = 1'b0;
    ld_status      = ST_OK;
    ld_data        = 8'd0;
    ld_has         = 1'b0;
    ld_last        = 1'b1;
    ram_we         = 1'b0;

    if (phase_r == PH_EMIT_RD) begin
      phase_nxt = PH_EMIT_WR;
    end else if (phase_r == PH_EMIT_WR) begin
      if (out_free) begin
        ld_out  = 1'b1;
        ld_has  = 1'b1;
        ld_data = ram_rdata;
        ld_last = emit_last;
        if (emit_last) begin
          phase_nxt = PH_IDLE;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
          phase_nxt  = PH_EMIT_RD;
        end
      end
    end else if (in_fire) begin
      if (in_tuser == OP_ARM) begin
        phase_nxt      = PH_SEEK;
        byte_count_nxt = '0;
        sum_nxt        = '0;
        wait_nxt       = '0;
      end else if (phase_r != PH_IDLE && in_tuser == OP_TICK) begin
        wait_nxt = wait_inc;
        if (timeout_r != 16'd0 && wait_inc >= timeout_r) begin
          ld_out    = 1'b1;
          ld_status = ST_TIMEOUT;
          phase_nxt = PH_IDLE;
        end
      end else if (phase_r != PH_IDLE && in_tuser == OP_BYTE) begin
        if (phase_r != PH_SEEK) begin
          wait_nxt = '0;
        end
        unique case (phase_r)
          PH_SEEK: begin
            // drop bytes until the header; the timer keeps running
            if (in_tdata == HEADER_BYTE) begin
              sum_nxt        = HEADER_BYTE;
              byte_count_nxt = '0;
              wait_nxt       = '0;
              phase_nxt      = PH_ADDR;
            end
          end
          PH_ADDR: begin
            sum_nxt   = sum_r + in_tdata;
            phase_nxt = (in_tdata == station_r) ? PH_CMD : PH_CMD_BADADDR;
          end
          PH_CMD_BADADDR: begin
            ld_out    = 1'b1;
            ld_status = ST_BAD_ADDR;
            phase_nxt = PH_IDLE;
          end
          PH_CMD: begin
            if (in_tdata != cmd_a_r && in_tdata != cmd_b_r) begin
              ld_out    = 1'b1;
              ld_status = ST_BAD_CMD;
              phase_nxt = PH_IDLE;
            end else begin
              sum_nxt        = sum_r + in_tdata;
              byte_count_nxt = '0;
              phase_nxt      = (eff_len == '0) ? PH_CSUM : PH_DATA;
            end
          end
          PH_DATA: begin
            ram_we         = store_ok;
            byte_count_nxt = count_inc;
            sum_nxt        = sum_r + in_tdata;
            if (count_inc >= eff_len) begin
              phase_nxt = PH_CSUM;
            end
          end
          PH_CSUM: begin
            if (in_tdata != sum_r) begin
              ld_out    = 1'b1;
              ld_status = ST_BAD_CSUM;
              phase_nxt = PH_IDLE;
            end else if (byte_count_r == '0) begin
              ld_out    = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              rd_idx_nxt = '0;
              phase_nxt  = PH_EMIT_RD;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
      out_has_r    <= ld_has;
      out_last_r   <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r, out_status_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_no_input_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !emitting)
    else $error("input transfer taken during payload replay");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= MAX_CNT)
    else $error("payload count beyond store depth");

  a_replay_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EMIT_RD || phase_r == PH_EMIT_WR) |-> byte_count_r != '0)
    else $error("replay started with empty payload");

  a_replay_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EMIT_WR && out_free && !emit_last) |=>
      (phase_r == PH_EMIT_RD && rd_idx_r == $past(rd_idx_r) + IDX_W'(1)))
    else $error("replay index did not advance");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for reply_frame_receiver_core. Frames are checked against a
// byte-level model of the receiver: header seek, address and command check,
// payload capture, sum-8 checksum, tick timeout. Each input transfer updates
// a local copy of the receiver state. The expected payload bursts and status
// replies are compared in order with the output transfers. Both sides stall
// at random, and the register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;
  import rfr_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int         PAY_MAX    = DEF_MAX_PAYLOAD;
  localparam int         SETTLE_CYC = 2 * PAY_MAX + 8;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx;
  } in_item_t;

  typedef struct {
    status_t    st;
    logic [7:0] data;
    logic       has;
    logic       last;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] rx_byte
  logic [1:0]  in_tuser = '0;     // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [2:0] status, [10:3] data_byte
  logic [0:0]  out_tuser;         // [0] has_data
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  reply_frame_receiver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // register shadows
  logic [7:0]  m_station = RST_STATION;
  logic [7:0]  m_cmd_a   = RST_CMD_A;
  logic [7:0]  m_cmd_b   = RST_CMD_B;
  logic [4:0]  m_len     = RST_LENGTH;
  logic [15:0] m_tmo     = RST_TIMEOUT;

  // receiver state
  phase_t      ph = PH_IDLE;
  int          pay_cnt = 0;
  logic [7:0]  run_sum = '0;
  logic [15:0] wait_cnt = '0;
  logic [7:0]  pay_mem [PAY_MAX];

  in_item_t item_q[$];
  reply_t   reply_q[$];

  int  n_gen = 0, n_in = 0, n_out = 0, n_status = 0, n_bad = 0;
  bit  in_took = 1'b0, calm = 1'b0, hold_req = 1'b0;
  int  in_gap = 0, out_gap = 0, hold_left = 0;

  initial begin
    #800000;
    $display("timeout: %0d replies still expected", reply_q.size());
    $display("reply_frame_receiver_core: mismatch");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  task automatic queue_reply(status_t s, logic [7:0] d, logic h, logic l);
    reply_t r;
    r.st = s;
    r.data = d;
    r.has = h;
    r.last = l;
    reply_q.push_back(r);
  endtask

  task automatic end_reply(status_t s);
    ph = PH_IDLE;
    queue_reply(s, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic step_receiver(logic [1:0] op, logic [7:0] b);
    int len;
    int i;
    len = m_len;
    if (len > PAY_MAX) len = PAY_MAX;
    if (op == OP_ARM) begin
      ph = PH_SEEK;
      pay_cnt = 0;
      run_sum = '0;
      wait_cnt = '0;
    end else if (op == OP_UNUSED || ph == PH_IDLE) begin
      // ignored
    end else if (op == OP_TICK) begin
      if (wait_cnt != WAIT_MAX) wait_cnt++;
      if (m_tmo != 0 && wait_cnt >= m_tmo) end_reply(ST_TIMEOUT);
    end else if (ph == PH_SEEK) begin
      // discarded bytes leave the tick count alone
      if (b == HEADER_BYTE) begin
        run_sum = HEADER_BYTE;
        pay_cnt = 0;
        wait_cnt = '0;
        ph = PH_ADDR;
      end
    end else begin
      wait_cnt = '0;
      case (ph)
        PH_ADDR: begin
          run_sum += b;
          ph = (b == m_station) ? PH_CMD : PH_CMD_BADADDR;
        end
        PH_CMD_BADADDR: end_reply(ST_BAD_ADDR);
        PH_CMD: begin
          if (b != m_cmd_a && b != m_cmd_b) begin
            end_reply(ST_BAD_CMD);
          end else begin
            run_sum += b;
            pay_cnt = 0;
            ph = (len == 0) ? PH_CSUM : PH_DATA;
          end
        end
        PH_DATA: begin
          if (pay_cnt < PAY_MAX) begin
            pay_mem[pay_cnt] = b;
            pay_cnt++;
          end
          run_sum += b;
          if (pay_cnt >= len) ph = PH_CSUM;
        end
        PH_CSUM: begin
          if (b != run_sum) begin
            end_reply(ST_BAD_CSUM);
          end else begin
            ph = PH_IDLE;
            if (pay_cnt == 0) queue_reply(ST_OK, 8'h00, 1'b0, 1'b1);
            for (i = 0; i < pay_cnt; i++)
              queue_reply(ST_OK, pay_mem[i], 1'b1, i + 1 == pay_cnt);
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
  endtask

  task automatic push_item(logic [1:0] op, logic [7:0] b);
    in_item_t it;
    it.op = op;
    it.rx = b;
    item_q.push_back(it);
    n_gen++;
  endtask

  // Header, address, command, n payload bytes, checksum. keep < 0 sends the
  // whole frame, else only its first keep bytes.
  task automatic send_frame(logic [7:0] addr, logic [7:0] cmd, int n, logic [7:0] first,
                            logic [7:0] csum_xor, int keep, bit gappy);
    logic [7:0] fb[$];
    logic [7:0] sum;
    int i;
    fb.push_back(HEADER_BYTE);
    fb.push_back(addr);
    fb.push_back(cmd);
    for (i = 0; i < n; i++) fb.push_back(i == 0 ? first : rand_byte());
    sum = '0;
    for (i = 0; i < fb.size(); i++) sum += fb[i];
    fb.push_back(sum ^ csum_xor);
    for (i = 0; i < fb.size() && (keep < 0 || i < keep); i++) begin
      push_item(OP_BYTE, fb[i]);
      // at most one tick between frame bytes, so no timeout unless asked for
      if (gappy && (m_tmo == 0 || m_tmo > 2) && $urandom_range(0, 5) == 0)
        push_item(OP_TICK, rand_byte());
    end
  endtask

  task automatic push_frame(int kind);
    int len, cut;
    logic [7:0] cmd, bad;
    len = m_len;
    if (len > PAY_MAX) len = PAY_MAX;
    cmd = $urandom_range(0, 1) ? m_cmd_a : m_cmd_b;
    push_item(OP_ARM, rand_byte());
    repeat ($urandom_range(0, 2)) begin
      bad = rand_byte();
      if (bad == HEADER_BYTE) bad = ~bad;
      push_item(OP_BYTE, bad);
    end
    case (kind)
      6: begin
        do bad = rand_byte(); while (bad == m_station);
        send_frame(bad, cmd, len, rand_byte(), 8'h00, -1, 1'b1);
      end
      7: begin
        do bad = rand_byte(); while (bad == m_cmd_a || bad == m_cmd_b);
        send_frame(m_station, bad, len, rand_byte(), 8'h00, -1, 1'b1);
      end
      8: send_frame(m_station, cmd, len, rand_byte(), 8'($urandom_range(1, 255)), -1, 1'b1);
      9: begin
        // stop short of the checksum, then time out or let the next arm abandon it
        cut = $urandom_range(0, len + 3);
        bad = $urandom_range(0, 1) ? m_station : ~m_station;
        send_frame(bad, cmd, len, rand_byte(), 8'h00, cut, 1'b0);
        if ($urandom_range(0, 1) == 1 && m_tmo != 0 && m_tmo <= 16)
          repeat (m_tmo) push_item(OP_TICK, rand_byte());
      end
      default: send_frame(m_station, cmd, len, rand_byte(), 8'h00, -1, 1'b1);
    endcase
    if ($urandom_range(0, 3) == 0) push_item(2'($urandom_range(1, 3)), rand_byte());
  endtask

  // Random frames, closed by a good frame so the receiver ends disarmed.
  task automatic run_random(int n);
    int stop;
    stop = n_gen + n;
    while (n_gen < stop) push_frame($urandom_range(0, 9));
    push_frame(0);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_STATION: m_station = val[7:0];
      REG_CMD_A:   m_cmd_a = val[7:0];
      REG_CMD_B:   m_cmd_b = val[7:0];
      REG_LENGTH:  m_len = val[4:0];
      REG_TIMEOUT: m_tmo = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (item_q.size() != 0) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // input side: offer items at the falling edge, hold until the transfer
  always @(negedge clk) begin : feed
    in_item_t head;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold the offered item
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      in_gap = $urandom_range(0, 6);
      in_tvalid <= 1'b0;
    end else if (item_q.size() != 0) begin
      head = item_q[0];
      in_tvalid <= 1'b1;
      in_tuser <= head.op;
      in_tdata <= head.rx;
    end else begin
      in_tvalid <= 1'b0;
    end
    in_took = 1'b0;
  end

  always @(posedge clk) begin : take
    in_item_t it;
    if (rst_n && in_tvalid && in_tready) begin
      it = item_q.pop_front();
      step_receiver(it.op, it.rx);
      n_in++;
      in_took = 1'b1;
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 250;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check
    reply_t w;
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (!out_tuser[0]) n_status++;
      if (reply_q.size() == 0) begin
        if (n_bad < 10)
          $display("unexpected result: status %0d data %h has %b last %b",
                   out_tdata[2:0], out_tdata[10:3], out_tuser[0], out_tlast);
        n_bad++;
      end else begin
        w = reply_q.pop_front();
        if (out_tdata[2:0] != w.st || out_tdata[10:3] != w.data ||
            out_tuser[0] != w.has || out_tlast != w.last) begin
          if (n_bad < 10)
            $display("result %0d: expected status %0d data %h has %b last %b, got %0d %h %b %b",
                     n_out, w.st, w.data, w.has, w.last,
                     out_tdata[2:0], out_tdata[10:3], out_tuser[0], out_tlast);
          n_bad++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: ignored traffic while idle, good frame behind noise,
    // bad address, bad command, re-arm mid-frame then bad checksum
    push_item(OP_UNUSED, HEADER_BYTE);
    push_item(OP_BYTE, HEADER_BYTE);
    push_item(OP_TICK, 8'h00);
    push_item(OP_ARM, 8'hFF);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    send_frame(RST_STATION, RST_CMD_A, 1, 8'hFF, 8'h00, -1, 1'b0);
    push_item(OP_ARM, 8'h00);
    send_frame(8'h00, RST_CMD_A, 0, 8'h00, 8'h00, 3, 1'b0);
    push_item(OP_ARM, 8'h00);
    send_frame(RST_STATION, 8'h31, 0, 8'h00, 8'h00, 3, 1'b0);
    push_item(OP_ARM, 8'h00);
    send_frame(RST_STATION, RST_CMD_A, 0, 8'h00, 8'h00, 2, 1'b0);
    push_item(OP_ARM, 8'h00);
    send_frame(RST_STATION, RST_CMD_A, 1, 8'h00, 8'h80, -1, 1'b0);
    settle();

    // empty payload, one-tick timeout, timeout while a bad address waits
    write_reg(REG_STATION, 16'h0000);
    write_reg(REG_CMD_A, 16'h00FF);
    write_reg(REG_CMD_B, 16'h0000);
    write_reg(REG_LENGTH, 16'd0);
    write_reg(REG_TIMEOUT, 16'd1);
    push_item(OP_ARM, 8'h00);
    push_item(OP_TICK, 8'hFF);
    push_item(OP_ARM, 8'h00);
    send_frame(8'h00, 8'h00, 0, 8'h00, 8'h00, -1, 1'b0);
    push_item(OP_ARM, 8'h00);
    send_frame(8'h80, 8'hFF, 0, 8'h00, 8'h00, 2, 1'b0);
    push_item(OP_TICK, 8'h00);
    run_random(8);
    settle();

    // oversize length clamps to the store depth; no timeout; long stall
    write_reg(REG_STATION, 16'h00FF);
    write_reg(REG_CMD_A, 16'h0030);
    write_reg(REG_CMD_B, 16'h00A5);
    write_reg(REG_LENGTH, 16'd31);
    write_reg(REG_TIMEOUT, 16'd0);
    @(posedge clk);
    hold_req = 1'b1;
    run_random(12);
    settle();

    write_reg(REG_STATION, 16'(rand_byte()));
    write_reg(REG_CMD_A, 16'(rand_byte()));
    write_reg(REG_CMD_B, 16'(rand_byte()));
    write_reg(REG_LENGTH, 16'($urandom_range(1, 8)));
    write_reg(REG_TIMEOUT, 16'd5);
    run_random(10);
    settle();

    // final stretch without stalls
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(REG_STATION, 16'h005A);
    write_reg(REG_LENGTH, 16'(PAY_MAX));
    write_reg(REG_TIMEOUT, 16'hFFFF);
    calm = 1'b1;
    run_random(6);
    settle();

    $display("covered %0d input transfers and %0d result transfers (%0d status-only)",
             n_in, n_out, n_status);
    $display("over five register settings incl. zero/oversize length and 0/1/max timeout");
    if (n_bad == 0) begin
      $display("reply_frame_receiver_core: match");
    end else begin
      $display("%0d result errors", n_bad);
      $display("reply_frame_receiver_core: mismatch");
    end
    $finish;
  end

endmodule
